[sv/fpalu_pkg.sv]
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared types, operation and status codes, and saturation helpers for the
// signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    // operation codes carried in req_type
    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV,
        OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE,
        OP_MIN, OP_MAX, OP_INC, OP_DEC,
        OP_FROM_INT, OP_TO_INT
    } t_op;

    // status codes
    typedef enum logic [1:0] {
        ST_OK,
        ST_SAT,
        ST_DIVZ
    } t_status;

    // one result transaction
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     cmp;
        t_status                  st;
    } t_res;

    // clamp a wide signed value into the val_bits range
    function automatic t_res sat_signed(input logic signed [65:0] v,
                                        input int unsigned val_bits);
        logic signed [65:0] vmax;
        logic signed [65:0] vmin;
        t_res               r;
        vmax  = (66'sd1 <<< (val_bits - 1)) - 66'sd1;
        vmin  = -vmax - 66'sd1;
        r.cmp = 1'b0;
        r.st  = ST_OK;
        if (v > vmax) begin
            r.value = vmax[DATA_W-1:0];
            r.st    = ST_SAT;
        end else if (v < vmin) begin
            r.value = vmin[DATA_W-1:0];
            r.st    = ST_SAT;
        end else begin
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // apply a sign to an unsigned magnitude, then clamp
    function automatic t_res sat_mag(input logic [63:0] mag, input logic neg,
                                     input int unsigned val_bits);
        logic signed [65:0] v;
        v = $signed({2'b00, mag});
        if (neg) begin
            v = -v;
        end
        return sat_signed(v, val_bits);
    endfunction

endpackage

[sv/fpalu_req_if.sv]
// ----------------------------------------------------------------------------
// fpalu_req_if
// Request channel: valid/ready handshake with operation and two operands.
// ----------------------------------------------------------------------------
interface fpalu_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output req_type, output operand_a,
                    output operand_b, input ready);
    modport sink   (input valid, input req_type, input operand_a,
                    input operand_b, output ready);
endinterface

[sv/fpalu_res_if.sv]
// ----------------------------------------------------------------------------
// fpalu_res_if
// Result channel: valid/ready handshake with value, compare flag and status.
// ----------------------------------------------------------------------------
interface fpalu_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         status;

    modport source (output valid, output result_value, output compare_true,
                    output status, input ready);
    modport sink   (input valid, input result_value, input compare_true,
                    input status, output ready);
endinterface

[sv/fpalu_simple.sv]
// ----------------------------------------------------------------------------
// fpalu_simple
// Combinational operations: add, sub, compares, min/max, inc/dec, integer
// conversions, divide-by-zero handling, and operand magnitudes.
// ----------------------------------------------------------------------------
module fpalu_simple #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
    parameter int VAL_BITS  = fpalu_pkg::DATA_W
) (
    input  fpalu_pkg::t_op                     i_op,
    input  logic signed [fpalu_pkg::DATA_W-1:0] i_a,
    input  logic signed [fpalu_pkg::DATA_W-1:0] i_b,
    output fpalu_pkg::t_res                    o_res,
    output logic [fpalu_pkg::DATA_W-1:0]       o_mag_a,
    output logic [fpalu_pkg::DATA_W-1:0]       o_mag_b,
    output logic                               o_neg
);

    localparam int DW = fpalu_pkg::DATA_W;
    localparam logic signed [DW-1:0] VMAX = DW'((64'sd1 <<< (VAL_BITS - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] VMIN = -VMAX - DW'(1);

    logic signed [65:0] wa;
    logic signed [65:0] wb;

    // wide operands for overflow-free sums
    assign wa = {{(66-DW){i_a[DW-1]}}, i_a};
    assign wb = {{(66-DW){i_b[DW-1]}}, i_b};

    // magnitudes and result sign for mul/div
    assign o_mag_a = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign o_mag_b = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
    assign o_neg   = i_a[DW-1] ^ i_b[DW-1];

    // operation select
    always_comb begin
        o_res.value = '0;
        o_res.cmp   = 1'b0;
        o_res.st    = fpalu_pkg::ST_OK;
        case (i_op)
            fpalu_pkg::OP_ADD:      o_res = fpalu_pkg::sat_signed(wa + wb, VAL_BITS);
            fpalu_pkg::OP_SUB:      o_res = fpalu_pkg::sat_signed(wa - wb, VAL_BITS);
            fpalu_pkg::OP_INC:      o_res = fpalu_pkg::sat_signed(wa + 66'sd1, VAL_BITS);
            fpalu_pkg::OP_DEC:      o_res = fpalu_pkg::sat_signed(wa - 66'sd1, VAL_BITS);
            fpalu_pkg::OP_FROM_INT: o_res = fpalu_pkg::sat_signed(wa <<< FRAC_BITS,
                                                                  VAL_BITS);
            fpalu_pkg::OP_TO_INT:   o_res.value = i_a >>> FRAC_BITS;
            fpalu_pkg::OP_GT:       o_res.cmp = (i_a > i_b);
            fpalu_pkg::OP_LT:       o_res.cmp = (i_a < i_b);
            fpalu_pkg::OP_GE:       o_res.cmp = (i_a >= i_b);
            fpalu_pkg::OP_LE:       o_res.cmp = (i_a <= i_b);
            fpalu_pkg::OP_EQ:       o_res.cmp = (i_a == i_b);
            fpalu_pkg::OP_NE:       o_res.cmp = (i_a != i_b);
            fpalu_pkg::OP_MIN:      o_res.value = (i_a < i_b) ? i_a : i_b;
            fpalu_pkg::OP_MAX:      o_res.value = (i_a > i_b) ? i_a : i_b;
            fpalu_pkg::OP_DIV: begin
                // divide by zero resolves here; real quotients come later
                if (i_b == '0) begin
                    o_res.st = fpalu_pkg::ST_DIVZ;
                    if (i_a > 0) begin
                        o_res.value = VMAX;
                    end else if (i_a < 0) begin
                        o_res.value = VMIN;
                    end
                end
            end
            default: begin
                o_res.value = '0;
            end
        endcase
    end

endmodule

[sv/fpalu_div.sv]
// ----------------------------------------------------------------------------
// fpalu_div
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpalu_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = fpalu_pkg::DATA_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_nq;

        // stage inputs
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
        end

        // shift in next numerator bit, trial subtract
        always_comb begin
            trial = {rem_in, nq_in[NUM_W-1]};
            ge    = (trial >= {1'b0, den_in});
            n_rem = ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
            n_nq  = {nq_in[NUM_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_nq[NUM_W-1];
    assign o_rem = r_rem[NUM_W-1];
    assign o_den = r_den[NUM_W-1];

endmodule

[sv/fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU with saturation and rounding.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per transaction (req_type, operand_a,
//   operand_b); o_res returns one transaction per request, in order, with
//   result_value, compare_true and status.
//   Every operation takes the same path: an input register, an operand /
//   simple-operation stage, FRAC_BITS+32 divider stages (one quotient bit
//   each), and an output register; multiply rounds inside that path.
//   Throughput is one transaction per cycle while o_res is not stalled.
//   When o_res is held not ready with a result waiting, the whole pipeline
//   freezes and i_req.ready drops in the same cycle; nothing is dropped or
//   repeated. A pending result stays on o_res until taken.
//   Reset (synchronous, active low) clears all valid bits; in-flight
//   transactions are discarded and no result is presented after reset.
//   Operands use their low VAL_BITS bits, sign-extended, where VAL_BITS is
//   WORD_BITS capped at 32.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
    parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpalu_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpalu_req_if.sink   i_req,
    fpalu_res_if.source o_res
);

    localparam int DW       = fpalu_pkg::DATA_W;
    localparam int VAL_BITS = (WORD_BITS < DW) ? WORD_BITS : DW;
    localparam int SH       = DW - VAL_BITS;
    localparam int NUM_W    = DW + FRAC_BITS;
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    typedef struct packed {
        fpalu_pkg::t_res res;
        logic            div;
        logic            neg;
    } t_side;

    logic en;

    // stage A
    logic                 r_a_vld;
    fpalu_pkg::t_op       r_a_op;
    logic signed [DW-1:0] r_a_a;
    logic signed [DW-1:0] r_a_b;
    logic signed [DW-1:0] n_a_a;
    logic signed [DW-1:0] n_a_b;

    // stage B
    fpalu_pkg::t_res      s_res;
    logic [DW-1:0]        s_mag_a;
    logic [DW-1:0]        s_mag_b;
    logic                 s_neg;
    logic                 r_b_vld;
    fpalu_pkg::t_res      r_b_res;
    logic [63:0]          r_b_prod;
    logic                 r_b_neg;
    logic                 r_b_mul;
    logic                 r_b_div;
    logic [NUM_W-1:0]     r_b_num;
    logic [DW-1:0]        r_b_den;

    // multiply finish and sideband line
    logic [63:0]          m_mag;
    fpalu_pkg::t_res      m_res;
    t_side                n_side0;
    t_side                r_sb  [NUM_W];
    logic                 r_vld [NUM_W];

    // divider outputs and final stage
    logic [NUM_W-1:0]     d_quo;
    logic [DW-1:0]        d_rem;
    logic [DW-1:0]        d_den;
    logic                 d_round;
    fpalu_pkg::t_res      d_res;
    logic                 r_out_vld;
    fpalu_pkg::t_res      r_out;

    // global advance: output empty or being taken
    assign en          = !r_out_vld || o_res.ready;
    assign i_req.ready = en;

    // operand sign extension from VAL_BITS
    assign n_a_a = (i_req.operand_a <<< SH) >>> SH;
    assign n_a_b = (i_req.operand_b <<< SH) >>> SH;

    // stage A registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_req.valid;
        end
        if (en) begin
            r_a_op <= fpalu_pkg::t_op'(i_req.req_type);
            r_a_a  <= n_a_a;
            r_a_b  <= n_a_b;
        end
    end

    fpalu_simple #(
        .FRAC_BITS (FRAC_BITS),
        .VAL_BITS  (VAL_BITS)
    ) u_simple (
        .i_op    (r_a_op),
        .i_a     (r_a_a),
        .i_b     (r_a_b),
        .o_res   (s_res),
        .o_mag_a (s_mag_a),
        .o_mag_b (s_mag_b),
        .o_neg   (s_neg)
    );

    // stage B registers: simple result, product, divider operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b_res  <= s_res;
            r_b_prod <= s_mag_a * s_mag_b;
            r_b_neg  <= s_neg;
            r_b_mul  <= (r_a_op == fpalu_pkg::OP_MUL);
            r_b_div  <= (r_a_op == fpalu_pkg::OP_DIV) && (r_a_b != '0);
            r_b_num  <= {s_mag_a, {FRAC_BITS{1'b0}}};
            r_b_den  <= s_mag_b;
        end
    end

    // multiply rounding (half away from zero on magnitude) and clamp
    always_comb begin
        m_mag = (r_b_prod + HALF) >> FRAC_BITS;
        m_res = fpalu_pkg::sat_mag(m_mag, r_b_neg, VAL_BITS);
        n_side0.res = r_b_mul ? m_res : r_b_res;
        n_side0.div = r_b_div;
        n_side0.neg = r_b_neg;
    end

    fpalu_div #(
        .NUM_W (NUM_W),
        .DEN_W (DW)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_b_num),
        .i_den (r_b_den),
        .o_quo (d_quo),
        .o_rem (d_rem),
        .o_den (d_den)
    );

    // sideband line alongside the divider stages
    for (genvar k = 0; k < NUM_W; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= (k == 0) ? r_b_vld : r_vld[(k == 0) ? 0 : k-1];
            end
            if (en) begin
                r_sb[k] <= (k == 0) ? n_side0 : r_sb[(k == 0) ? 0 : k-1];
            end
        end
    end

    // divide rounding and clamp
    always_comb begin
        d_round = ({d_rem, 1'b0} >= {1'b0, d_den});
        d_res   = fpalu_pkg::sat_mag(64'(d_quo) + 64'(d_round),
                                     r_sb[NUM_W-1].neg, VAL_BITS);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NUM_W-1];
        end
        if (en) begin
            r_out <= r_sb[NUM_W-1].div ? d_res : r_sb[NUM_W-1].res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.result_value = r_out.value;
    assign o_res.compare_true = r_out.cmp;
    assign o_res.status       = r_out.st;

`ifndef SYNTHESIS
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.compare_true |->
            o_res.status == fpalu_pkg::ST_OK && o_res.result_value == '0)
        else $error("compare result with nonzero value or status");

    a_divz_no_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == fpalu_pkg::ST_DIVZ |-> !o_res.compare_true)
        else $error("divide-by-zero status with compare flag");

    a_ready_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_res.valid || o_res.ready))
        else $error("input ready does not follow output stall");

    a_tail_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_out_vld == $past(r_vld[NUM_W-1]))
        else $error("valid lost between last stage and output");
`endif

endmodule
